/* hw/rtl/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the character LCD bus controller
// Transaction types, command classes, sequencer phases and bus constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clcd_pkg;

    // operation codes of an input transaction
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_INIT    = 3'd1;
    localparam logic [2:0] OP_WR_INST = 3'd2;
    localparam logic [2:0] OP_WR_DATA = 3'd3;
    localparam logic [2:0] OP_GOTO    = 3'd4;

    localparam logic [15:0] TICKS_PER_MS_RESET = 16'd1000;

    localparam logic [7:0] GOTO_BASE  = 8'h80;
    localparam logic [7:0] GOTO_ROW1  = 8'h40;
    localparam logic [7:0] ADDR_MAX   = 8'hCF;
    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;
    localparam int         BUSY_BIT   = 3;    // bit 7 of the byte, in the upper nibble

    // init sequence steps
    localparam logic [3:0] STEP_NONE  = 4'd0;
    localparam logic [3:0] STEP_START = 4'd1;
    localparam logic [3:0] STEP_POLL  = 4'd9;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_value;
        logic       row;
        logic [7:0] column;
        logic [3:0] bus_nibble;
    } t_in_item;

    typedef struct packed {
        logic       rs_line;
        logic       rw_line;
        logic       enable_line;
        logic [3:0] bus_out;
        logic       bus_drive;
        logic       ready_res;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_INIT,
        CMD_BYTE,
        CMD_DROP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte_value;
        logic       select;
        logic [3:0] bus_nibble;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_RD_HI,
        PH_RD_LO,
        PH_WR_HI,
        PH_WR_LO
    } t_phase;

    // instructions written after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        unique case (step)
            4'd10:   b = 8'h28;
            4'd11:   b = 8'h08;
            4'd12:   b = 8'h01;
            4'd13:   b = 8'h06;
            4'd14:   b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/clcd_fifo.sv */
// ----------------------------------------------------------------------------
// clcd_fifo: small register queue
// Generic first-in first-out buffer, DEPTH of at least 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hw/rtl/clcd_front.sv */
// ----------------------------------------------------------------------------
// clcd_front: command intake
// Classifies each input transaction, forms and range-checks goto addresses,
// and queues the result for the bus sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_front #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  clcd_pkg::t_in_item i_item,
    output clcd_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);

    clcd_pkg::t_cmd w_cmd;
    logic [7:0]     w_addr;
    logic           w_empty;

    assign w_addr = (clcd_pkg::GOTO_BASE | (i_item.row ? clcd_pkg::GOTO_ROW1 : 8'h00))
                  + i_item.column;

    always_comb begin
        w_cmd.kind       = clcd_pkg::CMD_TICK;
        w_cmd.byte_value = i_item.byte_value;
        w_cmd.select     = 1'b0;
        w_cmd.bus_nibble = i_item.bus_nibble;
        unique case (i_item.operation)
            clcd_pkg::OP_INIT: begin
                w_cmd.kind = clcd_pkg::CMD_INIT;
            end
            clcd_pkg::OP_WR_INST: begin
                w_cmd.kind = clcd_pkg::CMD_BYTE;
            end
            clcd_pkg::OP_WR_DATA: begin
                w_cmd.kind   = clcd_pkg::CMD_BYTE;
                w_cmd.select = 1'b1;
            end
            clcd_pkg::OP_GOTO: begin
                w_cmd.byte_value = w_addr;
                // address wraps at 8 bits, so a low result is out of range too
                if (w_addr[7] && (w_addr <= clcd_pkg::ADDR_MAX)) begin
                    w_cmd.kind = clcd_pkg::CMD_BYTE;
                end else begin
                    w_cmd.kind = clcd_pkg::CMD_DROP;
                end
            end
            default: begin
                w_cmd.kind = clcd_pkg::CMD_TICK;
            end
        endcase
    end

    clcd_fifo #(
        .WIDTH ($bits(clcd_pkg::t_cmd)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (w_empty)
    );

    assign o_cmd_valid = !w_empty;

endmodule

/* hw/rtl/clcd_seq.sv */
// ----------------------------------------------------------------------------
// clcd_seq: bus sequencer
// Executes one queued transaction per cycle unless the result queue is full:
// busy-flag polls, nibble strobes, init waits, and the pin levels shown for that tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_ticks_per_ms,
    input  clcd_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output clcd_pkg::t_out_item o_res
);

    clcd_pkg::t_phase r_phase, n_phase;
    logic [19:0]      r_dc, n_dc;
    logic [3:0]       r_step, n_step;
    logic [7:0]       r_pb, n_pb;
    logic             r_sel, n_sel;
    logic [3:0]       r_ru, n_ru;
    logic             r_sh, n_sh;
    logic             r_rs, n_rs;
    logic             r_rw, n_rw;
    logic             r_en, n_en;
    logic             r_drv, n_drv;
    logic [3:0]       r_nib, n_nib;

    logic [15:0] w_len;
    logic [19:0] w_strobe;
    logic [19:0] w_wait15;
    logic [19:0] w_wait6;
    logic [19:0] w_wait2;
    logic        w_step;

    assign w_len    = (i_ticks_per_ms == 16'd0) ? 16'd1 : i_ticks_per_ms;
    assign w_strobe = {4'd0, w_len};
    assign w_wait15 = {w_len, 4'd0} - w_strobe;
    assign w_wait6  = {2'd0, w_len, 2'd0} + {3'd0, w_len, 1'b0};
    assign w_wait2  = {3'd0, w_len, 1'b0};

    assign w_step     = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = w_step;
    assign o_res_push = w_step;

    always_comb begin
        logic             v_done;
        logic             v_finish;
        logic             v_release;
        logic             s_rs, s_rw, s_en, s_drv;
        logic [3:0]       s_nib;
        clcd_pkg::t_status v_status;

        n_phase   = r_phase;
        n_dc      = r_dc;
        n_step    = r_step;
        n_pb      = r_pb;
        n_sel     = r_sel;
        n_ru      = r_ru;
        n_sh      = r_sh;
        n_rs      = r_rs;
        n_rw      = r_rw;
        n_en      = r_en;
        n_drv     = r_drv;
        n_nib     = r_nib;
        v_status  = clcd_pkg::ST_OK;
        v_finish  = 1'b0;
        v_release = 1'b0;

        // command part of the transaction
        if (i_cmd.kind != clcd_pkg::CMD_TICK) begin
            if (r_phase != clcd_pkg::PH_IDLE) begin
                v_status = clcd_pkg::ST_BUSY;
            end else begin
                unique case (i_cmd.kind)
                    clcd_pkg::CMD_INIT: begin
                        n_rs    = 1'b0;
                        n_rw    = 1'b0;
                        n_en    = 1'b0;
                        n_drv   = 1'b1;
                        n_step  = clcd_pkg::STEP_START;
                        n_phase = clcd_pkg::PH_WAIT;
                        n_dc    = w_wait15;
                    end
                    clcd_pkg::CMD_BYTE: begin
                        n_pb    = i_cmd.byte_value;
                        n_sel   = i_cmd.select;
                        n_sh    = 1'b0;
                        n_phase = clcd_pkg::PH_RD_HI;
                        n_dc    = w_strobe;
                    end
                    clcd_pkg::CMD_DROP: begin
                        v_status = clcd_pkg::ST_RANGE;
                    end
                    default: begin
                    end
                endcase
            end
        end

        // tick part
        v_done = (n_dc[19:1] == 19'd0);
        unique case (n_phase)
            clcd_pkg::PH_WAIT: begin
                n_en = 1'b0;
                if (v_done) begin
                    n_dc     = '0;
                    v_finish = 1'b1;
                end else begin
                    n_dc = n_dc - 20'd1;
                end
            end
            clcd_pkg::PH_RD_HI: begin
                n_rs  = 1'b0;
                n_rw  = 1'b1;
                n_en  = 1'b1;
                n_drv = 1'b0;
                if (v_done) begin
                    n_dc = '0;
                    if (!n_sh) begin
                        n_ru = i_cmd.bus_nibble;
                    end
                    n_phase = clcd_pkg::PH_RD_LO;
                end else begin
                    n_dc = n_dc - 20'd1;
                end
            end
            clcd_pkg::PH_RD_LO: begin
                n_rs  = 1'b0;
                n_rw  = 1'b1;
                n_en  = 1'b0;
                n_drv = 1'b0;
                if (!n_sh) begin
                    n_sh    = 1'b1;
                    n_phase = clcd_pkg::PH_RD_HI;
                    n_dc    = w_strobe;
                end else if (n_ru[clcd_pkg::BUSY_BIT]) begin
                    // still busy: poll again
                    n_sh    = 1'b0;
                    n_phase = clcd_pkg::PH_RD_HI;
                    n_dc    = w_strobe;
                end else if (n_step == clcd_pkg::STEP_POLL) begin
                    v_finish = 1'b1;
                end else begin
                    n_sh    = 1'b0;
                    n_phase = clcd_pkg::PH_WR_HI;
                    n_dc    = w_strobe;
                end
            end
            clcd_pkg::PH_WR_HI, clcd_pkg::PH_WR_LO: begin
                n_nib = n_sh ? n_pb[3:0] : n_pb[7:4];
                n_drv = 1'b1;
                n_rs  = n_sel;
                n_rw  = 1'b0;
                n_en  = (n_phase == clcd_pkg::PH_WR_HI);
                if (n_phase == clcd_pkg::PH_WR_HI) begin
                    if (v_done) begin
                        n_dc    = '0;
                        n_phase = clcd_pkg::PH_WR_LO;
                    end else begin
                        n_dc = n_dc - 20'd1;
                    end
                end else if (!n_sh) begin
                    n_sh    = 1'b1;
                    n_phase = clcd_pkg::PH_WR_HI;
                    n_dc    = w_strobe;
                end else begin
                    // wake-up nibbles keep the bus driven through their wait
                    v_release = !(n_step == 4'd2 || n_step == 4'd4 ||
                                  n_step == 4'd6 || n_step == 4'd8);
                    v_finish  = 1'b1;
                end
            end
            default: begin
                n_phase = clcd_pkg::PH_IDLE;
                n_en    = 1'b0;
            end
        endcase

        s_rs  = n_rs;
        s_rw  = n_rw;
        s_en  = n_en;
        s_drv = n_drv;
        s_nib = n_nib;
        if (v_release) begin
            n_drv = 1'b0;
        end

        // end of an action: next init step, or back to idle
        if (v_finish) begin
            if (n_step != clcd_pkg::STEP_NONE) begin
                n_step = n_step + 4'd1;
                unique case (n_step)
                    4'd1: begin
                        n_phase = clcd_pkg::PH_WAIT;
                        n_dc    = w_wait15;
                    end
                    4'd3: begin
                        n_phase = clcd_pkg::PH_WAIT;
                        n_dc    = w_wait6;
                    end
                    4'd5, 4'd7: begin
                        n_phase = clcd_pkg::PH_WAIT;
                        n_dc    = w_wait2;
                    end
                    4'd2, 4'd4, 4'd6, 4'd8: begin
                        n_pb    = {4'd0, (n_step == 4'd8) ? clcd_pkg::NIB_4BIT
                                                          : clcd_pkg::NIB_WAKE};
                        n_sel   = 1'b0;
                        n_sh    = 1'b1;
                        n_phase = clcd_pkg::PH_WR_HI;
                        n_dc    = w_strobe;
                    end
                    4'd9: begin
                        n_sh    = 1'b0;
                        n_phase = clcd_pkg::PH_RD_HI;
                        n_dc    = w_strobe;
                    end
                    4'd10, 4'd11, 4'd12, 4'd13, 4'd14: begin
                        n_pb    = clcd_pkg::init_byte(n_step);
                        n_sel   = 1'b0;
                        n_sh    = 1'b0;
                        n_phase = clcd_pkg::PH_RD_HI;
                        n_dc    = w_strobe;
                    end
                    default: begin
                        n_step  = clcd_pkg::STEP_NONE;
                        n_phase = clcd_pkg::PH_IDLE;
                    end
                endcase
            end else begin
                n_phase = clcd_pkg::PH_IDLE;
            end
        end

        o_res.rs_line     = s_rs;
        o_res.rw_line     = s_rw;
        o_res.enable_line = s_en;
        o_res.bus_out     = s_drv ? s_nib : 4'd0;
        o_res.bus_drive   = s_drv;
        o_res.ready_res   = (n_phase == clcd_pkg::PH_IDLE);
        o_res.status      = v_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= clcd_pkg::PH_IDLE;
            r_dc    <= '0;
            r_step  <= clcd_pkg::STEP_NONE;
            r_pb    <= '0;
            r_sel   <= 1'b0;
            r_ru    <= '0;
            r_sh    <= 1'b0;
            r_rs    <= 1'b0;
            r_rw    <= 1'b0;
            r_en    <= 1'b0;
            r_drv   <= 1'b0;
            r_nib   <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_step  <= n_step;
            r_pb    <= n_pb;
            r_sel   <= n_sel;
            r_ru    <= n_ru;
            r_sh    <= n_sh;
            r_rs    <= n_rs;
            r_rw    <= n_rw;
            r_en    <= n_en;
            r_drv   <= n_drv;
            r_nib   <= n_nib;
        end
    end

endmodule

/* hw/rtl/char_lcd_nibble_bus_controller_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_controller_core: 4-bit character LCD bus controller
// Path: an accepted transaction is registered in the command queue, then the
// sequencer step writes its result into the result queue.
// Throughput: one transaction per cycle while the result queue is not full.
// Reset: synchronous, clears both queues, the sequencer and ticks_per_ms to 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_nibble_bus_controller_core #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  clcd_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output clcd_pkg::t_out_item o_out_item
);

    logic [15:0]         r_ticks_per_ms;
    clcd_pkg::t_cmd      w_cmd;
    logic                w_cmd_valid;
    logic                w_cmd_pop;
    logic                w_res_full;
    logic                w_res_push;
    clcd_pkg::t_out_item w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_ms <= clcd_pkg::TICKS_PER_MS_RESET;
        end else if (i_cfg_we) begin
            r_ticks_per_ms <= i_cfg_wdata;
        end
    end

    clcd_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in_item),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    clcd_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ticks_per_ms (r_ticks_per_ms),
        .i_cmd          (w_cmd),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_pop      (w_cmd_pop),
        .i_res_full     (w_res_full),
        .o_res_push     (w_res_push),
        .o_res          (w_res)
    );

    clcd_fifo #(
        .WIDTH ($bits(clcd_pkg::t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

/* hw/rtl/clcd_checker.sv */
// ----------------------------------------------------------------------------
// clcd_checker: port-level checks for the LCD bus controller
// Watches the queue handshakes and result pins; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clcd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input clcd_pkg::t_in_item  i_in_item,
    input clcd_pkg::t_out_item o_out_item
);

    // the result queue comes out of reset empty and the command queue not full
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed while stalled");

    // released bus reads as zero
    a_bus_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.bus_drive) |-> (o_out_item.bus_out == 4'd0))
        else $error("bus_out nonzero while not driving");

    // a strobe high tick is always mid-sequence
    a_en_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.enable_line) |-> !o_out_item.ready_res)
        else $error("ready while enable high");

    // never drive the pins during a read
    a_rw_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_out_item.rw_line && o_out_item.bus_drive))
        else $error("bus driven during read");

endmodule

bind char_lcd_nibble_bus_controller_core clcd_checker u_clcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .i_in_item  (i_in_item),
    .o_out_item (o_out_item)
);

/* tb/tb_char_lcd_nibble_bus_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_bus_controller_core: self-checking bench for the LCD core
// Pushes tick and command transactions through the input queue, predicts the
// pin levels of every tick with a cycle model of the bus sequencer and checks
// each popped result field by field. Covers the reset strobe length, the
// shortest and a long strobe, init, goto range checks and busy rejects.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_char_lcd_nibble_bus_controller_core;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 90;

    localparam logic [15:0] LONG_TICKS = 16'd200;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [7:0] PIN_RS  = 8'h01;
    localparam logic [7:0] PIN_RW  = 8'h02;
    localparam logic [7:0] PIN_EN  = 8'h04;
    localparam logic [7:0] PIN_DRV = 8'h08;

    localparam logic [7:0] INIT_CMDS [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG,
        ROW_SETTLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [15:0]          cfg;
        clcd_pkg::t_in_item   it;
        logic                 typed;
        clcd_pkg::t_out_item  want;
    } t_row;

    localparam clcd_pkg::t_out_item OUT_IDLE =
        {1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b1, clcd_pkg::ST_OK};
    localparam clcd_pkg::t_out_item OUT_DROP =
        {1'b0, 1'b0, 1'b0, 4'h0, 1'b0, 1'b1, clcd_pkg::ST_RANGE};
    localparam clcd_pkg::t_out_item NO_OUT   = '0;

    // first rows run at the reset strobe length with nothing started
    localparam t_row DIR_TBL [25] = '{
        {ROW_ITEM,   16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b1, OUT_IDLE},
        {ROW_ITEM,   16'd0, OP_SPARE_LO,          8'hFF, 1'b1, 8'hFF, 4'hF, 1'b1, OUT_IDLE},
        {ROW_ITEM,   16'd0, OP_SPARE_HI,          8'h00, 1'b0, 8'h00, 4'h0, 1'b1, OUT_IDLE},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b1, 8'h10, 4'h0, 1'b1, OUT_DROP},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b0, 8'h80, 4'h0, 1'b1, OUT_DROP},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b0, 8'hFF, 4'h0, 1'b1, OUT_DROP},
        {ROW_CFG,    16'd1, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_INIT,    8'h00, 1'b0, 8'h00, 4'h8, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b1, 8'h0F, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b1, 8'hFF, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_WR_INST, 8'hFF, 1'b0, 8'h00, 4'hF, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_WR_DATA, 8'h5A, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_WR_DATA, 8'h00, 1'b1, 8'hFF, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_INIT,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_GOTO,    8'h00, 1'b0, 8'h05, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_CFG,    16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_ITEM,   16'd0, clcd_pkg::OP_WR_DATA, 8'hA5, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT},
        {ROW_SETTLE, 16'd0, clcd_pkg::OP_TICK,    8'h00, 1'b0, 8'h00, 4'h0, 1'b0, NO_OUT}
    };

    localparam logic [15:0] PHASE_TICKS [RAND_PHASES] =
        '{16'd2, 16'd1, 16'd7, 16'd0, 16'd3, 16'd1, 16'd12, 16'd2, 16'd4, 16'd1};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [15:0]         i_cfg_wdata = '0;
    logic                push        = 1'b0;
    logic                full;
    clcd_pkg::t_in_item  i_in_item   = '0;
    logic                empty;
    logic                pop         = 1'b0;
    clcd_pkg::t_out_item o_out_item;

    char_lcd_nibble_bus_controller_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer model state
    logic [15:0]      ms_ticks   = clcd_pkg::TICKS_PER_MS_RESET;
    clcd_pkg::t_phase lcd_phase  = clcd_pkg::PH_IDLE;
    logic [19:0]      dly        = '0;
    logic [3:0]       init_idx   = clcd_pkg::STEP_NONE;
    logic [7:0]       pend_byte  = '0;
    logic             pend_rs    = 1'b0;
    logic [3:0]       upper_nib  = '0;
    logic             second_nib = 1'b0;
    logic [7:0]       pins       = '0;

    clcd_pkg::t_out_item pin_frames_q [$];
    int                  errors      = 0;
    int                  idle_cycles = 0;
    int                  stall_left  = 0;
    logic                quiet       = 1'b0;

    function automatic logic [19:0] strobe_ticks();
        return (ms_ticks == 16'd0) ? 20'd1 : {4'd0, ms_ticks};
    endfunction

    function automatic void start_poll();
        second_nib = 1'b0;
        lcd_phase  = clcd_pkg::PH_RD_HI;
        dly        = strobe_ticks();
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic sel);
        pend_byte = b;
        pend_rs   = sel;
        start_poll();
    endfunction

    function automatic void start_wait(input logic [19:0] ms);
        lcd_phase = clcd_pkg::PH_WAIT;
        dly       = ms * strobe_ticks();
    endfunction

    // wake-up nibble: a single low-half strobe
    function automatic void start_nibble(input logic [3:0] nib);
        pend_byte  = {4'h0, nib};
        pend_rs    = 1'b0;
        second_nib = 1'b1;
        lcd_phase  = clcd_pkg::PH_WR_HI;
        dly        = strobe_ticks();
    endfunction

    function automatic void run_init_step();
        case (init_idx)
            clcd_pkg::STEP_START:     start_wait(20'd15);
            4'd3:                     start_wait(20'd6);
            4'd5, 4'd7:               start_wait(20'd2);
            4'd2, 4'd4, 4'd6:         start_nibble(clcd_pkg::NIB_WAKE);
            4'd8:                     start_nibble(clcd_pkg::NIB_4BIT);
            clcd_pkg::STEP_POLL:      start_poll();
            4'd10, 4'd11, 4'd12, 4'd13, 4'd14: begin
                start_byte(INIT_CMDS[init_idx - 4'd10], 1'b0);
            end
            default: begin
                init_idx  = clcd_pkg::STEP_NONE;
                lcd_phase = clcd_pkg::PH_IDLE;
            end
        endcase
    endfunction

    function automatic void finish_action();
        if (init_idx != clcd_pkg::STEP_NONE) begin
            init_idx = init_idx + 4'd1;
            run_init_step();
        end else begin
            lcd_phase = clcd_pkg::PH_IDLE;
        end
    endfunction

    function automatic logic count_done();
        if (dly > 20'd1) begin
            dly = dly - 20'd1;
            return 1'b0;
        end
        dly = '0;
        return 1'b1;
    endfunction

    // one tick of the sequencer; returns the pins shown during that tick
    function automatic clcd_pkg::t_out_item predict_pins(input clcd_pkg::t_in_item it);
        clcd_pkg::t_out_item res;
        clcd_pkg::t_status   st;
        logic [7:0]          shown;
        logic [7:0]          addr;
        logic [3:0]          nib;
        st = clcd_pkg::ST_OK;
        if (it.operation >= clcd_pkg::OP_INIT && it.operation <= clcd_pkg::OP_GOTO) begin
            if (lcd_phase != clcd_pkg::PH_IDLE) begin
                st = clcd_pkg::ST_BUSY;
            end else begin
                case (it.operation)
                    clcd_pkg::OP_INIT: begin
                        pins     = (pins & 8'hF0) | PIN_DRV;
                        init_idx = clcd_pkg::STEP_START;
                        run_init_step();
                    end
                    clcd_pkg::OP_WR_INST: start_byte(it.byte_value, 1'b0);
                    clcd_pkg::OP_WR_DATA: start_byte(it.byte_value, 1'b1);
                    default: begin
                        addr = (clcd_pkg::GOTO_BASE | (it.row ? clcd_pkg::GOTO_ROW1 : 8'h00))
                             + it.column;
                        if (addr >= clcd_pkg::GOTO_BASE && addr <= clcd_pkg::ADDR_MAX) begin
                            start_byte(addr, 1'b0);
                        end else begin
                            st = clcd_pkg::ST_RANGE;
                        end
                    end
                endcase
            end
        end

        case (lcd_phase)
            clcd_pkg::PH_WAIT: begin
                pins  = pins & ~PIN_EN;
                shown = pins;
                if (count_done()) finish_action();
            end
            clcd_pkg::PH_RD_HI: begin
                pins  = (pins & 8'hF0) | PIN_RW | PIN_EN;
                shown = pins;
                if (count_done()) begin
                    if (!second_nib) upper_nib = it.bus_nibble;
                    lcd_phase = clcd_pkg::PH_RD_LO;
                end
            end
            clcd_pkg::PH_RD_LO: begin
                pins  = (pins & 8'hF0) | PIN_RW;
                shown = pins;
                if (!second_nib) begin
                    second_nib = 1'b1;
                    lcd_phase  = clcd_pkg::PH_RD_HI;
                    dly        = strobe_ticks();
                end else if (upper_nib[clcd_pkg::BUSY_BIT]) begin
                    start_poll();
                end else if (init_idx == clcd_pkg::STEP_POLL) begin
                    finish_action();
                end else begin
                    second_nib = 1'b0;
                    lcd_phase  = clcd_pkg::PH_WR_HI;
                    dly        = strobe_ticks();
                end
            end
            clcd_pkg::PH_WR_HI, clcd_pkg::PH_WR_LO: begin
                nib   = second_nib ? pend_byte[3:0] : pend_byte[7:4];
                pins  = {nib, 4'h0} | PIN_DRV | (pend_rs ? PIN_RS : 8'h00)
                      | ((lcd_phase == clcd_pkg::PH_WR_HI) ? PIN_EN : 8'h00);
                shown = pins;
                if (lcd_phase == clcd_pkg::PH_WR_HI) begin
                    if (count_done()) lcd_phase = clcd_pkg::PH_WR_LO;
                end else if (!second_nib) begin
                    second_nib = 1'b1;
                    lcd_phase  = clcd_pkg::PH_WR_HI;
                    dly        = strobe_ticks();
                end else begin
                    // wake-up nibbles keep the bus driven into the next wait
                    if (!(init_idx inside {4'd2, 4'd4, 4'd6, 4'd8})) pins = pins & ~PIN_DRV;
                    finish_action();
                end
            end
            default: begin
                lcd_phase = clcd_pkg::PH_IDLE;
                pins      = pins & ~PIN_EN;
                shown     = pins;
            end
        endcase

        res.rs_line     = shown[0];
        res.rw_line     = shown[1];
        res.enable_line = shown[2];
        res.bus_out     = shown[3] ? shown[7:4] : 4'h0;
        res.bus_drive   = shown[3];
        res.ready_res   = (lcd_phase == clcd_pkg::PH_IDLE);
        res.status      = st;
        return res;
    endfunction

    function automatic clcd_pkg::t_in_item tick_item();
        clcd_pkg::t_in_item it;
        it.operation  = clcd_pkg::OP_TICK;
        it.byte_value = 8'($urandom);
        it.row        = 1'($urandom_range(0, 1));
        it.column     = 8'($urandom);
        it.bus_nibble = 4'($urandom);
        return it;
    endfunction

    // commands mostly land on an idle sequencer; a few hit it busy
    function automatic clcd_pkg::t_in_item rand_item();
        clcd_pkg::t_in_item it;
        int unsigned        r;
        it = tick_item();
        r  = $urandom_range(0, 99);
        if (r < ((lcd_phase == clcd_pkg::PH_IDLE) ? 60 : 8)) begin
            r = $urandom_range(0, 99);
            if (r < 6)       it.operation = clcd_pkg::OP_INIT;
            else if (r < 40) it.operation = clcd_pkg::OP_WR_INST;
            else if (r < 72) it.operation = clcd_pkg::OP_WR_DATA;
            else begin
                it.operation = clcd_pkg::OP_GOTO;
                if ($urandom_range(0, 2) != 0) begin
                    it.column = it.row ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 79));
                end
            end
        end else if (r >= 97) begin
            it.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input clcd_pkg::t_in_item it, input logic typed,
                             input clcd_pkg::t_out_item want);
        clcd_pkg::t_out_item pred;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = predict_pins(it);
        pin_frames_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic settle_queue();
        push <= 1'b0;
        while (pin_frames_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_ticks(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ms_ticks     = v;
    endtask

    task automatic run_until_idle();
        while (lcd_phase != clcd_pkg::PH_IDLE) send_item(tick_item(), 1'b0, NO_OUT);
    endtask

    task automatic check_result(input clcd_pkg::t_out_item got,
                                input clcd_pkg::t_out_item want);
        if (got.rs_line !== want.rs_line) begin
            $error("rs_line expected %0d got %0d", want.rs_line, got.rs_line);
            errors++;
        end
        if (got.rw_line !== want.rw_line) begin
            $error("rw_line expected %0d got %0d", want.rw_line, got.rw_line);
            errors++;
        end
        if (got.enable_line !== want.enable_line) begin
            $error("enable_line expected %0d got %0d", want.enable_line, got.enable_line);
            errors++;
        end
        if (got.bus_out !== want.bus_out) begin
            $error("bus_out expected %0h got %0h", want.bus_out, got.bus_out);
            errors++;
        end
        if (got.bus_drive !== want.bus_drive) begin
            $error("bus_drive expected %0d got %0d", want.bus_drive, got.bus_drive);
            errors++;
        end
        if (got.ready_res !== want.ready_res) begin
            $error("ready_res expected %0d got %0d", want.ready_res, got.ready_res);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            errors++;
        end
    endtask

    // result side: random stall bursts, none while quiet
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            pop        <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL char_lcd_nibble_bus_controller_core");
                $finish;
            end
            if (pop && !empty) begin
                if (pin_frames_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    check_result(o_out_item, pin_frames_q.pop_front());
                end
            end
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_TBL[k]) begin
            case (DIR_TBL[k].kind)
                ROW_ITEM: send_item(DIR_TBL[k].it, DIR_TBL[k].typed, DIR_TBL[k].want);
                ROW_CFG: begin
                    settle_queue();
                    write_ticks(DIR_TBL[k].cfg);
                end
                default: run_until_idle();
            endcase
        end

        // long strobe: run out the first busy read, then shorten the rest
        quiet = 1'b1;
        settle_queue();
        write_ticks(LONG_TICKS);
        send_item({clcd_pkg::OP_WR_INST, 8'($urandom), 1'b0, 8'h00, 4'h0}, 1'b0, NO_OUT);
        while (lcd_phase == clcd_pkg::PH_RD_HI) send_item(tick_item(), 1'b0, NO_OUT);
        settle_queue();
        write_ticks(16'd1);
        run_until_idle();
        quiet = 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_queue();
            write_ticks(PHASE_TICKS[p]);
            if (p == RAND_PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender off until the result queue runs dry
                if (p == 4 && n == PHASE_ITEMS / 2) settle_queue();
                send_item(rand_item(), 1'b0, NO_OUT);
            end
        end

        push <= 1'b0;
        while (pin_frames_q.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS char_lcd_nibble_bus_controller_core");
        end else begin
            $display("FAIL char_lcd_nibble_bus_controller_core");
        end
        $finish;
    end

endmodule
